/* sv/efps_pkg.sv */
package efps_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PICK,
    ST_SWEEP,
    ST_DRAIN
  } efps_state_t;

  localparam int SCNT_W     = 7;
  localparam int FPT_W      = 12;
  localparam int IDX_OUT_W  = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_POINT  = 1'b1;

  localparam logic [SCNT_W-1:0] SCNT_RESET = 7'd8;
  localparam logic [FPT_W-1:0]  FPT_RESET  = 12'd0;

endpackage

/* sv/efps_ram.sv */
module efps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/efps_dist_pipe.sv */
module efps_dist_pipe #(
  parameter int CW = 24,
  parameter int IW = 12,
  parameter int DW = 50
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [IW-1:0]   in_idx,
  input  logic [DW-1:0]   in_min,
  input  logic [3*CW-1:0] in_pt,
  input  logic [3*CW-1:0] in_ref,
  output logic            out_valid,
  output logic [IW-1:0]   out_idx,
  output logic [DW-1:0]   out_min,
  output logic [DW-1:0]   out_dist,
  output logic            active
);

  localparam int SQW    = 2 * CW;
  localparam int SUMW   = SQW + 2;
  localparam int STAGES = 4;

  logic                v_r   [STAGES];
  logic [IW-1:0]       idx_r [STAGES];
  logic [DW-1:0]       min_r [STAGES];

  logic signed [CW:0]  diff_nxt [3];
  logic signed [CW:0]  diff_r   [3];
  logic [CW:0]         mag_nxt  [3];
  logic [CW:0]         mag_r    [3];
  logic [SQW-1:0]      sq_nxt   [3];
  logic [SQW-1:0]      sq_r     [3];
  logic [SUMW-1:0]     sum;
  logic [SUMW-1:0]     sum_max;
  logic [DW-1:0]       dist_nxt;
  logic [DW-1:0]       dist_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff_nxt[a] = $signed({in_pt[a*CW+CW-1], in_pt[a*CW +: CW]})
                  - $signed({in_ref[a*CW+CW-1], in_ref[a*CW +: CW]});
      mag_nxt[a]  = diff_r[a][CW] ? $unsigned(-diff_r[a]) : $unsigned(diff_r[a]);
      sq_nxt[a]   = SQW'(mag_r[a]) * SQW'(mag_r[a]);
    end
    sum     = SUMW'(sq_r[0]) + SUMW'(sq_r[1]) + SUMW'(sq_r[2]);
    sum_max = SUMW'({DW{1'b1}});
    // Only wide coordinates can exceed the stored width; they saturate.
    dist_nxt = (sum > sum_max) ? '1 : sum[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STAGES; s++) begin
        v_r[s] <= 1'b0;
      end
    end else begin
      v_r[0] <= in_valid;
      for (int s = 1; s < STAGES; s++) begin
        v_r[s] <= v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r[0] <= in_idx;
    min_r[0] <= in_min;
    for (int s = 1; s < STAGES; s++) begin
      idx_r[s] <= idx_r[s-1];
      min_r[s] <= min_r[s-1];
    end
    for (int a = 0; a < 3; a++) begin
      diff_r[a] <= diff_nxt[a];
      mag_r[a]  <= mag_nxt[a];
      sq_r[a]   <= sq_nxt[a];
    end
    dist_r <= dist_nxt;
  end

  assign out_valid = v_r[STAGES-1];
  assign out_idx   = idx_r[STAGES-1];
  assign out_min   = min_r[STAGES-1];
  assign out_dist  = dist_r;
  assign active    = v_r[0] | v_r[1] | v_r[2] | v_r[3];

endmodule

/* sv/euclidean_farthest_point_sampler.sv */
// Loading: one vertex per cycle, start is taken whenever busy is low.
// After the last vertex the first sample passes through the check state and the
// output register; each further sample takes one pass over the coordinate and
// distance memories (one read port each) plus a drain of the distance pipeline.
// Results are single-cycle strobes; the receiver cannot stall them.
// Synchronous reset returns control and configuration to their defaults; memories are not cleared.
module euclidean_farthest_point_sampler #(
  parameter int MAX_VERTICES = 4096,
  parameter int MAX_SAMPLES  = 64,
  parameter int COORD_WIDTH  = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_WIDTH-1:0]     in_x_coord,
  input  logic signed [COORD_WIDTH-1:0]     in_y_coord,
  input  logic signed [COORD_WIDTH-1:0]     in_z_coord,
  input  logic                              in_last_vertex,
  output logic                              out_valid,
  output logic [efps_pkg::IDX_OUT_W-1:0]    out_sample_index,
  output logic                              out_last_sample,
  output logic                              out_start_out_of_range,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [efps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [efps_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import efps_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int IW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int CMPW = (CNTW > FPT_W) ? CNTW : FPT_W;
  localparam int SUMW = 2 * CW + 2;
  localparam int DW   = (SUMW > 64) ? 64 : SUMW;

  efps_state_t       state_r, state_nxt;
  logic [SCNT_W-1:0] sample_count_r;
  logic [FPT_W-1:0]  first_point_r;
  logic [CNTW-1:0]   count_r;
  logic [IW-1:0]     j_r;
  logic [3*CW-1:0]   pick_pt_r;
  logic [DW-1:0]     best_d_r;
  logic [IW-1:0]     best_idx_r;
  logic [SCNT_W-1:0] emitted_r;
  logic              first_sweep_r;
  logic              rd_v_r;
  logic [IW-1:0]     rd_idx_r;
  logic              wb_v_r;
  logic [IW-1:0]     wb_idx_r;
  logic [DW-1:0]     wb_min_r;
  logic              out_valid_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic              out_last_r;
  logic              out_oor_r;

  logic [SCNT_W-1:0] want;
  logic              store_en;
  logic              fp_oor;
  logic              j_last;
  logic              pipe_empty;
  logic [IW-1:0]     rd_addr;
  logic              issue;
  logic              latch_pick;
  logic              emit;
  logic              emit_oor;
  logic              emit_last;
  logic [IDX_OUT_W-1:0] emit_idx;
  logic [IW+FPT_W-1:0]  fp_ext;
  logic [IW-1:0]        fp_idx;
  logic [IW+IDX_OUT_W-1:0] best_ext;
  logic [3*CW-1:0]   pt_rd;
  logic [DW-1:0]     min_rd;
  logic              p_valid;
  logic [IW-1:0]     p_idx;
  logic [DW-1:0]     p_min;
  logic [DW-1:0]     p_dist;
  logic              pipe_active;
  logic [DW-1:0]     new_min;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;
  assign store_en  = start && !busy && (count_r < CNTW'(MAX_VERTICES));
  assign fp_oor    = CMPW'(first_point_r) >= CMPW'(count_r);
  assign j_last    = CNTW'(j_r) == (count_r - CNTW'(1));
  assign pipe_empty = !rd_v_r && !pipe_active && !wb_v_r;
  assign fp_ext    = {{IW{1'b0}}, first_point_r};
  assign fp_idx    = fp_ext[IW-1:0];
  assign best_ext  = {{IDX_OUT_W{1'b0}}, best_idx_r};

  always_comb begin
    if (sample_count_r == '0) begin
      want = SCNT_W'(1);
    end else if (sample_count_r > SCNT_W'(MAX_SAMPLES)) begin
      want = SCNT_W'(MAX_SAMPLES);
    end else begin
      want = sample_count_r;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rd_addr    = j_r;
    issue      = 1'b0;
    latch_pick = 1'b0;
    emit       = 1'b0;
    emit_oor   = 1'b0;
    emit_last  = 1'b0;
    emit_idx   = first_point_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_last_vertex) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        emit = 1'b1;
        if (fp_oor) begin
          emit_oor  = 1'b1;
          emit_last = 1'b1;
          state_nxt = ST_IDLE;
        end else if (want == SCNT_W'(1)) begin
          emit_last = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          rd_addr   = fp_idx;
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        latch_pick = 1'b1;
        state_nxt  = ST_SWEEP;
      end
      ST_SWEEP: begin
        issue = 1'b1;
        if (j_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          emit     = 1'b1;
          emit_idx = best_ext[IDX_OUT_W-1:0];
          if (emitted_r + SCNT_W'(1) == want) begin
            emit_last = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            rd_addr   = best_idx_r;
            state_nxt = ST_PICK;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The first pass of a run overwrites whatever the distance store held.
  always_comb begin
    if (first_sweep_r || (p_dist < p_min)) begin
      new_min = p_dist;
    end else begin
      new_min = p_min;
    end
  end

  efps_ram #(
    .WIDTH (3 * CW),
    .DEPTH (MAX_VERTICES)
  ) u_coord_ram (
    .clk     (clk),
    .wr_en   (store_en),
    .wr_addr (count_r[IW-1:0]),
    .wr_data ({in_z_coord, in_y_coord, in_x_coord}),
    .rd_addr (rd_addr),
    .rd_data (pt_rd)
  );

  efps_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_VERTICES)
  ) u_dist_ram (
    .clk     (clk),
    .wr_en   (wb_v_r),
    .wr_addr (wb_idx_r),
    .wr_data (wb_min_r),
    .rd_addr (rd_addr),
    .rd_data (min_rd)
  );

  efps_dist_pipe #(
    .CW (CW),
    .IW (IW),
    .DW (DW)
  ) u_dist_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rd_v_r),
    .in_idx    (rd_idx_r),
    .in_min    (min_rd),
    .in_pt     (pt_rd),
    .in_ref    (pick_pt_r),
    .out_valid (p_valid),
    .out_idx   (p_idx),
    .out_min   (p_min),
    .out_dist  (p_dist),
    .active    (pipe_active)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      sample_count_r <= SCNT_RESET;
      first_point_r  <= FPT_RESET;
      count_r        <= '0;
      emitted_r      <= '0;
      first_sweep_r  <= 1'b0;
      rd_v_r         <= 1'b0;
      wb_v_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= issue;
      wb_v_r      <= p_valid;
      out_valid_r <= emit;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SAMPLE_COUNT: sample_count_r <= cfg_data[SCNT_W-1:0];
          CFG_FIRST_POINT:  first_point_r  <= cfg_data[FPT_W-1:0];
          default: ;
        endcase
      end
      if (store_en) begin
        count_r <= count_r + CNTW'(1);
      end else if (busy && (state_nxt == ST_IDLE)) begin
        count_r <= '0;
      end
      if (emit) begin
        if (state_r == ST_CHECK) begin
          emitted_r     <= SCNT_W'(1);
          first_sweep_r <= 1'b1;
        end else begin
          emitted_r     <= emitted_r + SCNT_W'(1);
          first_sweep_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= j_r;
    wb_idx_r <= p_idx;
    wb_min_r <= new_min;
    if (latch_pick) begin
      pick_pt_r  <= pt_rd;
      j_r        <= '0;
      best_d_r   <= '0;
      best_idx_r <= '0;
    end else begin
      if (issue) begin
        j_r <= j_r + IW'(1);
      end
      // Strictly greater keeps the lowest index on ties.
      if (wb_v_r && (wb_min_r > best_d_r)) begin
        best_d_r   <= wb_min_r;
        best_idx_r <= wb_idx_r;
      end
    end
    if (emit) begin
      out_idx_r  <= emit_idx;
      out_last_r <= emit_last;
      out_oor_r  <= emit_oor;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_sample_index       = out_idx_r;
  assign out_last_sample        = out_last_r;
  assign out_start_out_of_range = out_oor_r;

`ifndef ASSERT_OFF
  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a running transaction");

  a_wb_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    wb_v_r |-> (state_r == ST_SWEEP || state_r == ST_DRAIN))
    else $error("distance write-back outside a sweep");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!rd_v_r && !pipe_active && !wb_v_r))
    else $error("pipeline not empty while idle");

  a_oor_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_start_out_of_range) |-> out_last_sample)
    else $error("out-of-range result not marked last");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (emitted_r != '0 && emitted_r <= want))
    else $error("more results than requested");
`endif

endmodule

/* bench/efps_sample_checker.sv */
module efps_sample_checker #(
  parameter int MAX_VERTICES = 4096,
  parameter int MAX_SAMPLES  = 64,
  parameter int COORD_WIDTH  = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic signed [COORD_WIDTH-1:0]         in_x_coord,
  input  logic signed [COORD_WIDTH-1:0]         in_y_coord,
  input  logic signed [COORD_WIDTH-1:0]         in_z_coord,
  input  logic                                  in_last_vertex,
  input  logic                                  out_valid,
  input  logic [efps_pkg::IDX_OUT_W-1:0]        out_sample_index,
  input  logic                                  out_last_sample,
  input  logic                                  out_start_out_of_range,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [efps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [efps_pkg::CFG_DATA_W-1:0]       cfg_data,
  output int                                    mismatch_count,
  output int                                    samples_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import efps_pkg::*;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] index;
    logic                 last;
    logic                 out_of_range;
  } sample_t;

  sample_t expected_samples[$];

  logic signed [COORD_WIDTH-1:0] vx [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] vy [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] vz [MAX_VERTICES];
  longint unsigned nearest_sq [MAX_VERTICES];
  int              loaded;
  logic [SCNT_W-1:0] count_reg;
  logic [FPT_W-1:0]  first_reg;

  function automatic longint unsigned sq_distance(int a, int b);
    longint dx, dy, dz;
    dx = longint'(vx[a]) - longint'(vx[b]);
    dy = longint'(vy[a]) - longint'(vy[b]);
    dz = longint'(vz[a]) - longint'(vz[b]);
    return longint'(dx * dx + dy * dy + dz * dz);
  endfunction

  function automatic sample_t make_sample(int idx, bit last, bit oor);
    sample_t s;
    s.index        = idx[IDX_OUT_W-1:0];
    s.last         = last;
    s.out_of_range = oor;
    return s;
  endfunction

  function automatic void queue_sample(sample_t s);
    expected_samples.insert(expected_samples.size(), s);
  endfunction

  // Greedy selection over the loaded set, keeping for every vertex its
  // smallest squared distance to anything picked so far.
  task automatic predict_sample_run();
    int want;
    int pick;
    longint unsigned best;
    longint unsigned d;
    want = int'(count_reg);
    if (want == 0) want = 1;
    if (want > MAX_SAMPLES) want = MAX_SAMPLES;
    if (int'(first_reg) >= loaded) begin
      queue_sample(make_sample(int'(first_reg), 1'b1, 1'b1));
      return;
    end
    pick = int'(first_reg);
    for (int j = 0; j < loaded; j++) nearest_sq[j] = sq_distance(j, pick);
    queue_sample(make_sample(pick, want == 1, 1'b0));
    for (int k = 1; k < want; k++) begin
      best = 0;
      pick = 0;
      for (int j = 0; j < loaded; j++) begin
        if (nearest_sq[j] > best) begin
          best = nearest_sq[j];
          pick = j;
        end
      end
      queue_sample(make_sample(pick, k == want - 1, 1'b0));
      for (int j = 0; j < loaded; j++) begin
        d = sq_distance(j, pick);
        if (d < nearest_sq[j]) nearest_sq[j] = d;
      end
    end
  endtask

  always @(posedge clk) begin
    sample_t exp_s;
    if (!rst_n) begin
      loaded         = 0;
      count_reg      = SCNT_RESET;
      first_reg      = FPT_RESET;
      mismatch_count = 0;
      expected_samples.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SAMPLE_COUNT: count_reg = cfg_data[SCNT_W-1:0];
          CFG_FIRST_POINT:  first_reg = cfg_data[FPT_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        // Once the store is full, further vertices are dropped silently.
        if (loaded < MAX_VERTICES) begin
          vx[loaded] = in_x_coord;
          vy[loaded] = in_y_coord;
          vz[loaded] = in_z_coord;
          loaded++;
        end
        if (in_last_vertex) begin
          predict_sample_run();
          loaded = 0;
        end
      end
      if (out_valid) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample, expected none, actual index %0d last %0b oor %0b",
                   $time, out_sample_index, out_last_sample, out_start_out_of_range);
          mismatch_count++;
        end else begin
          exp_s = expected_samples.pop_front();
          if (out_sample_index !== exp_s.index) begin
            $display("%0t: sample_index expected %0d, actual %0d",
                     $time, exp_s.index, out_sample_index);
            mismatch_count++;
          end
          if (out_last_sample !== exp_s.last) begin
            $display("%0t: last_sample expected %0b, actual %0b",
                     $time, exp_s.last, out_last_sample);
            mismatch_count++;
          end
          if (out_start_out_of_range !== exp_s.out_of_range) begin
            $display("%0t: start_out_of_range expected %0b, actual %0b",
                     $time, exp_s.out_of_range, out_start_out_of_range);
            mismatch_count++;
          end
        end
      end
    end
    samples_outstanding = expected_samples.size();
  end

endmodule

/* bench/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import efps_pkg::*;

  localparam int COORD_W   = 24;
  localparam int MAX_VERTS = 4096;

  localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;

  typedef enum int {
    COORD_FULL,
    COORD_SMALL,
    COORD_EXTREME,
    COORD_SAME
  } coord_mode_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic signed [COORD_W-1:0] in_x_coord;
  logic signed [COORD_W-1:0] in_y_coord;
  logic signed [COORD_W-1:0] in_z_coord;
  logic                      in_last_vertex;
  logic                      out_valid;
  logic [IDX_OUT_W-1:0]      out_sample_index;
  logic                      out_last_sample;
  logic                      out_start_out_of_range;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  int mismatch_count;
  int samples_outstanding;

  logic start_taken;
  logic cfg_taken;
  int   last_load;
  int   fp_now;
  int   random_items;

  euclidean_farthest_point_sampler u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_x_coord            (in_x_coord),
    .in_y_coord            (in_y_coord),
    .in_z_coord            (in_z_coord),
    .in_last_vertex        (in_last_vertex),
    .out_valid             (out_valid),
    .out_sample_index      (out_sample_index),
    .out_last_sample       (out_last_sample),
    .out_start_out_of_range(out_start_out_of_range),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  efps_sample_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_x_coord            (in_x_coord),
    .in_y_coord            (in_y_coord),
    .in_z_coord            (in_z_coord),
    .in_last_vertex        (in_last_vertex),
    .out_valid             (out_valid),
    .out_sample_index      (out_sample_index),
    .out_last_sample       (out_last_sample),
    .out_start_out_of_range(out_start_out_of_range),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .mismatch_count        (mismatch_count),
    .samples_outstanding   (samples_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Handshake flags are registered so that the stimulus, which runs on the
  // falling edge, sees what was accepted at the preceding rising edge.
  always @(posedge clk) begin
    start_taken <= start && !busy;
    cfg_taken   <= cfg_valid && cfg_ready;
  end

  initial begin
    #3ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic signed [COORD_W-1:0] pick_coord(coord_mode_t mode);
    case (mode)
      COORD_SMALL:   return COORD_W'($signed($urandom_range(0, 4)) - 2);
      COORD_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return C_MAX;
          1:       return C_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      default:       return COORD_W'($urandom);
    endcase
  endfunction

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid = 1'b0;
  endtask

  task automatic write_count(int n);
    logic [CFG_DATA_W-1:0] data;
    // Bits above the register width are junk and must be ignored.
    data = CFG_DATA_W'($urandom);
    data[SCNT_W-1:0] = n[SCNT_W-1:0];
    write_register(CFG_SAMPLE_COUNT, data);
  endtask

  task automatic write_first(int fp);
    write_register(CFG_FIRST_POINT, fp[FPT_W-1:0]);
    fp_now = fp;
  endtask

  // Start is left high after a transaction when the next one follows at once.
  task automatic send_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z, logic last, int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_x_coord     = x;
    in_y_coord     = y;
    in_z_coord     = z;
    in_last_vertex = last;
    start          = 1'b1;
    do @(negedge clk); while (!start_taken);
  endtask

  task automatic send_set(int n, coord_mode_t mode, bit burst);
    logic signed [COORD_W-1:0] same_x, same_y, same_z;
    same_x = COORD_W'($urandom);
    same_y = COORD_W'($urandom);
    same_z = COORD_W'($urandom);
    for (int i = 0; i < n; i++) begin
      if (mode == COORD_SAME) begin
        send_vertex(same_x, same_y, same_z, i == n - 1, burst ? 0 : $urandom_range(0, 7));
      end else begin
        send_vertex(pick_coord(mode), pick_coord(mode), pick_coord(mode), i == n - 1,
                    burst ? 0 : $urandom_range(0, 7));
      end
    end
    last_load = (n > MAX_VERTS) ? MAX_VERTS : n;
  endtask

  // Once every expected sample has been seen the block is idle again; a short
  // quiet spell follows before the registers are touched.
  task automatic wait_idle();
    start = 1'b0;
    while (samples_outstanding != 0) @(negedge clk);
    repeat (last_load + 20) @(negedge clk);
  endtask

  initial begin
    int r;
    int n;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_x_coord     = '0;
    in_y_coord     = '0;
    in_z_coord     = '0;
    in_last_vertex = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_SAMPLE_COUNT;
    cfg_data       = '0;
    last_load      = 0;
    fp_now         = 0;
    random_items   = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings with extreme coordinates.
    send_vertex(C_MAX, C_MAX, C_MAX, 1'b0, 0);
    send_vertex(C_MIN, C_MIN, C_MIN, 1'b0, 2);
    send_vertex('0, '0, '0, 1'b0, 0);
    send_vertex(C_MAX, C_MIN, '0, 1'b1, 1);
    last_load = 4;
    wait_idle();

    // A sample count of zero behaves as one.
    write_count(0);
    write_first(2);
    send_set(3, COORD_FULL, 1'b0);
    wait_idle();

    // First point beyond the loaded set.
    write_first(5);
    send_set(2, COORD_FULL, 1'b1);
    wait_idle();

    // Oversized count saturates; duplicate vertices give ties and zero maxima.
    write_count(127);
    write_first(1);
    send_vertex(24'sd1, 24'sd1, 24'sd1, 1'b0, 0);
    send_vertex(-24'sd1, -24'sd1, -24'sd1, 1'b0, 0);
    send_vertex(24'sd1, 24'sd1, 24'sd1, 1'b0, 3);
    send_vertex(-24'sd1, -24'sd1, -24'sd1, 1'b0, 0);
    send_vertex('0, '0, '0, 1'b1, 0);
    last_load = 5;
    wait_idle();

    write_count(1);
    write_first(0);
    send_set(1, COORD_FULL, 1'b0);
    wait_idle();

    // A lone vertex with the largest count: every later pick falls back to 0.
    write_count(64);
    send_set(1, COORD_EXTREME, 1'b0);
    wait_idle();

    while (random_items < 250) begin
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 9);
        case (r)
          0:       write_count(0);
          1:       write_count(1);
          2:       write_count(64);
          3:       write_count($urandom_range(65, 127));
          default: write_count($urandom_range(2, 63));
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 9);
        case (r)
          0:       write_first(MAX_VERTS - 1);
          1:       write_first($urandom_range(0, MAX_VERTS - 1));
          default: write_first($urandom_range(0, 7));
        endcase
      end
      repeat ($urandom_range(1, 3)) begin
        if (fp_now < 64 && $urandom_range(0, 99) < 85) n = fp_now + 1 + $urandom_range(0, 20);
        else n = $urandom_range(1, 20);
        send_set(n, coord_mode_t'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
        random_items += n;
      end
      wait_idle();
    end

    if (mismatch_count == 0 && samples_outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/efps_pkg.sv
sv/efps_ram.sv
sv/efps_dist_pipe.sv
sv/euclidean_farthest_point_sampler.sv
bench/efps_sample_checker.sv
bench/tb.sv
